// ----- rtl/mcwd_pkg.sv -----
package mcwd_pkg;

    // Default size of the watchdog bank and of each countdown.
    localparam int NUM_WATCHDOGS_DEF = 4;
    localparam int COUNT_WIDTH_DEF   = 32;

    // Operation codes carried in flag bits 15..8.
    localparam logic [7:0] OP_START     = 8'h01;
    localparam logic [7:0] OP_STOP      = 8'h02;
    localparam logic [7:0] OP_QUERY     = 8'h03;
    localparam logic [7:0] OP_QUERY_LPM = 8'h04;

    // Action codes carried in flag bits 7..0.
    localparam logic [7:0] ACT_FIRST = 8'h01;
    localparam logic [7:0] ACT_LAST  = 8'h03;

    // Query-LPM answer: the watchdogs keep running in low power mode.
    localparam logic [63:0] LPM_NOT_STOPPED = 64'd2;

    // Input mode and result kind codes.
    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_TICK    = 1'b1;
    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_EXPIRY  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_PARAM   = 2'd1,
        STAT_NUMBER  = 2'd2,
        STAT_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Decoded effect of one command on the watchdog bank.
    typedef struct packed {
        t_status     status;
        logic [63:0] word;
        logic        do_start;
        logic        do_stop;
        logic        stop_all;
        logic [1:0]  action;
    } t_cmd_ctl;

endpackage

// ----- rtl/mcwd_item_if.sv -----
interface mcwd_item_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] flags;
    logic [63:0] watchdog_number;
    logic [63:0] timeout_ms;

    modport source (output valid, mode, flags, watchdog_number, timeout_ms, input ready);
    modport sink   (input valid, mode, flags, watchdog_number, timeout_ms, output ready);
endinterface

// ----- rtl/mcwd_result_if.sv -----
interface mcwd_result_if #(
    parameter int IDX_W = 2
);
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic [1:0]       status;
    logic [63:0]      reply_word;
    logic [IDX_W-1:0] expired_index;
    logic [1:0]       expired_action;
    logic             last;

    modport source (output valid, result_kind, status, reply_word, expired_index,
                    expired_action, last, input ready);
    modport sink   (input valid, result_kind, status, reply_word, expired_index,
                    expired_action, last, output ready);
endinterface

// ----- rtl/mcwd_cfg_if.sv -----
interface mcwd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/mcwd_cmd_check.sv -----
module mcwd_cmd_check #(
    parameter int NUM_WATCHDOGS = mcwd_pkg::NUM_WATCHDOGS_DEF,
    parameter int COUNT_WIDTH   = mcwd_pkg::COUNT_WIDTH_DEF
) (
    input  logic [63:0]                          i_flags,
    input  logic [63:0]                          i_num,
    input  logic [63:0]                          i_tmo,
    input  logic [15:0]                          i_min,
    output mcwd_pkg::t_cmd_ctl                   o_ctl,
    output logic [((NUM_WATCHDOGS > 1) ? $clog2(NUM_WATCHDOGS) : 1)-1:0] o_slot,
    output logic [COUNT_WIDTH-1:0]               o_load
);
    localparam int IDX_W = (NUM_WATCHDOGS > 1) ? $clog2(NUM_WATCHDOGS) : 1;
    // Bits of a timeout that lie above the countdown width.
    localparam logic [63:0] HI_MASK = ~((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [7:0] op;
    logic [7:0] act;
    logic       bad_common;
    logic       num_big;
    logic       num_all;
    logic       tmo_low;
    logic       act_bad;

    assign op         = i_flags[15:8];
    assign act        = i_flags[7:0];
    assign bad_common = (|i_flags[63:17]) || (i_num == 64'd0);
    assign num_big    = i_num > 64'(NUM_WATCHDOGS);
    assign num_all    = &i_num;
    assign tmo_low    = i_tmo <= {48'd0, i_min};

    // The slot is only used for numbers 1..NUM, so the low bits suffice.
    assign o_slot = i_num[IDX_W-1:0] - IDX_W'(1);

    // Saturate the timeout to the countdown width.
    assign o_load = (|(i_tmo & HI_MASK)) ? '1 : i_tmo[COUNT_WIDTH-1:0];

    // Decode the operation and run its checks in order.
    always_comb begin
        act_bad        = !(act inside {[mcwd_pkg::ACT_FIRST:mcwd_pkg::ACT_LAST]});
        o_ctl          = '0;
        o_ctl.status   = mcwd_pkg::STAT_OK;
        o_ctl.action   = act[1:0] - 2'd1;
        if (bad_common) begin
            o_ctl.status = mcwd_pkg::STAT_PARAM;
        end else begin
            case (op)
                mcwd_pkg::OP_START: begin
                    if (num_big) begin
                        o_ctl.status = mcwd_pkg::STAT_NUMBER;
                    end else if (tmo_low) begin
                        o_ctl.status = mcwd_pkg::STAT_TIMEOUT;
                    end else if (act_bad) begin
                        o_ctl.status = mcwd_pkg::STAT_PARAM;
                    end else begin
                        o_ctl.do_start = 1'b1;
                    end
                end
                mcwd_pkg::OP_STOP: begin
                    if (num_all) begin
                        o_ctl.stop_all = 1'b1;
                    end else if (!num_big) begin
                        o_ctl.do_stop = 1'b1;
                    end else begin
                        o_ctl.status = mcwd_pkg::STAT_NUMBER;
                    end
                end
                mcwd_pkg::OP_QUERY: begin
                    o_ctl.word = {i_min, 16'(NUM_WATCHDOGS), 32'd0};
                end
                mcwd_pkg::OP_QUERY_LPM: begin
                    if (num_big) begin
                        o_ctl.status = mcwd_pkg::STAT_NUMBER;
                    end else begin
                        o_ctl.word = mcwd_pkg::LPM_NOT_STOPPED;
                    end
                end
                default: begin
                    o_ctl.status = mcwd_pkg::STAT_PARAM;
                end
            endcase
        end
    end

endmodule

// ----- rtl/multi_channel_watchdog_controller_core.sv -----
// Bank of NUM_WATCHDOGS countdown watchdogs. A command item (mode 0) starts, stops or
// queries watchdogs and always yields exactly one reply with last set; the item is
// captured, and the reply register is loaded in the CMD state once the result register
// is free. A tick item (mode 1) is scanned by one shared compare-and-decrement unit that
// visits the watchdogs one per cycle in ascending order, unless an expiry waits for the
// result channel; each countdown that runs out disarms and yields one expiry item; the
// final expiry of a tick carries last, and a tick with no expiry yields nothing. Back
// pressure on the result channel stalls replies and the scan. The input is ready
// only between items; the min_timeout_ms register (reset value 1) may be written at any
// time through the configuration channel, which is always ready.
module multi_channel_watchdog_controller_core #(
    parameter int NUM_WATCHDOGS = mcwd_pkg::NUM_WATCHDOGS_DEF,
    parameter int COUNT_WIDTH   = mcwd_pkg::COUNT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcwd_item_if.sink      i_item,
    mcwd_cfg_if.sink       i_cfg,
    mcwd_result_if.source  o_result
);
    localparam int IDX_W = (NUM_WATCHDOGS > 1) ? $clog2(NUM_WATCHDOGS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WATCHDOGS - 1);

    // Control state.
    mcwd_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_min;
    logic             r_pend_valid;
    logic             r_out_valid;

    // Payload state.
    logic [NUM_WATCHDOGS-1:0] r_armed;
    logic [COUNT_WIDTH-1:0]   r_count  [NUM_WATCHDOGS];
    logic [1:0]               r_action [NUM_WATCHDOGS];
    logic [63:0]              r_flags;
    logic [63:0]              r_num;
    logic [63:0]              r_tmo;
    logic [IDX_W-1:0]         r_pend_idx;
    logic [1:0]               r_pend_act;
    logic                     r_out_kind;
    logic [1:0]               r_out_status;
    logic [63:0]              r_out_word;
    logic [IDX_W-1:0]         r_out_idx;
    logic [1:0]               r_out_act;
    logic                     r_out_last;

    // Command decode.
    mcwd_pkg::t_cmd_ctl     cmd_ctl;
    logic [IDX_W-1:0]       cmd_slot;
    logic [COUNT_WIDTH-1:0] cmd_load;

    // Sequencer controls.
    logic in_ready;
    logic in_fire;
    logic out_free;
    logic cmd_fire;
    logic scan_adv;
    logic push_pend;
    logic flush_push;

    // Shared compare-and-decrement unit.
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   cur_armed;
    logic                   cur_le1;
    logic [COUNT_WIDTH-1:0] cur_dec;
    logic                   expire;

    mcwd_cmd_check #(
        .NUM_WATCHDOGS (NUM_WATCHDOGS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_cmd_check (
        .i_flags (r_flags),
        .i_num   (r_num),
        .i_tmo   (r_tmo),
        .i_min   (r_min),
        .o_ctl   (cmd_ctl),
        .o_slot  (cmd_slot),
        .o_load  (cmd_load)
    );

    assign cur_count = r_count[r_idx];
    assign cur_armed = r_armed[r_idx];
    assign cur_le1   = cur_count <= COUNT_WIDTH'(1);
    assign cur_dec   = cur_count - COUNT_WIDTH'(1);
    assign expire    = cur_armed && cur_le1;

    assign out_free = !r_out_valid || o_result.ready;
    assign in_fire  = i_item.valid && in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcwd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (i_item.mode == mcwd_pkg::MODE_TICK) ?
                              mcwd_pkg::ST_SCAN : mcwd_pkg::ST_CMD;
                end
            end
            mcwd_pkg::ST_CMD: begin
                if (out_free) begin
                    n_state = mcwd_pkg::ST_IDLE;
                end
            end
            mcwd_pkg::ST_SCAN: begin
                if (scan_adv && (r_idx == LAST_IDX)) begin
                    n_state = mcwd_pkg::ST_FLUSH;
                end
            end
            mcwd_pkg::ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = mcwd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready   = 1'b0;
        cmd_fire   = 1'b0;
        scan_adv   = 1'b0;
        push_pend  = 1'b0;
        flush_push = 1'b0;
        case (r_state)
            mcwd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            mcwd_pkg::ST_CMD: begin
                cmd_fire = out_free;
            end
            mcwd_pkg::ST_SCAN: begin
                // An expiry with one already pending must first move the pending one out.
                scan_adv  = !(expire && r_pend_valid && !out_free);
                push_pend = scan_adv && expire && r_pend_valid;
            end
            mcwd_pkg::ST_FLUSH: begin
                flush_push = r_pend_valid && out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    // Sequencer and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mcwd_pkg::ST_IDLE;
            r_idx        <= '0;
            r_min        <= 16'd1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_armed      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_min <= i_cfg.data;
            end
            if (in_fire) begin
                r_idx <= '0;
            end else if (scan_adv && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + IDX_W'(1);
            end

            // Watchdog arming.
            if (cmd_fire) begin
                if (cmd_ctl.do_start) begin
                    r_armed[cmd_slot] <= 1'b1;
                end else if (cmd_ctl.do_stop) begin
                    r_armed[cmd_slot] <= 1'b0;
                end else if (cmd_ctl.stop_all) begin
                    r_armed <= '0;
                end
            end else if (scan_adv && expire) begin
                r_armed[r_idx] <= 1'b0;
            end

            // The pending expiry waits until it is known whether another follows.
            if (scan_adv && expire) begin
                r_pend_valid <= 1'b1;
            end else if ((r_state == mcwd_pkg::ST_FLUSH) && (n_state == mcwd_pkg::ST_IDLE)) begin
                r_pend_valid <= 1'b0;
            end

            if (cmd_fire || push_pend || flush_push) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured item, watchdog payload and result register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_flags <= i_item.flags;
            r_num   <= i_item.watchdog_number;
            r_tmo   <= i_item.timeout_ms;
        end
        if (cmd_fire && cmd_ctl.do_start) begin
            r_count[cmd_slot]  <= cmd_load;
            r_action[cmd_slot] <= cmd_ctl.action;
        end else if (scan_adv && cur_armed && !cur_le1) begin
            r_count[r_idx] <= cur_dec;
        end
        if (scan_adv && expire) begin
            r_pend_idx <= r_idx;
            r_pend_act <= r_action[r_idx];
        end
        if (cmd_fire) begin
            r_out_kind   <= mcwd_pkg::KIND_REPLY;
            r_out_status <= cmd_ctl.status;
            r_out_word   <= cmd_ctl.word;
            r_out_idx    <= '0;
            r_out_act    <= 2'd0;
            r_out_last   <= 1'b1;
        end else if (push_pend || flush_push) begin
            r_out_kind   <= mcwd_pkg::KIND_EXPIRY;
            r_out_status <= mcwd_pkg::STAT_OK;
            r_out_word   <= 64'd0;
            r_out_idx    <= r_pend_idx;
            r_out_act    <= r_pend_act;
            r_out_last   <= flush_push;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.result_kind    = r_out_kind;
    assign o_result.status         = r_out_status;
    assign o_result.reply_word     = r_out_word;
    assign o_result.expired_index  = r_out_idx;
    assign o_result.expired_action = r_out_act;
    assign o_result.last           = r_out_last;

`ifndef SYNTHESIS
    // A pending expiry only exists while a tick is being worked on.
    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == mcwd_pkg::ST_SCAN || r_state == mcwd_pkg::ST_FLUSH))
        else $error("pending expiry outside a tick");

    // The scan index stays inside the bank.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("scan index beyond the last watchdog");

    // A command reply is always the only and final item of its command.
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == mcwd_pkg::KIND_REPLY) |-> r_out_last)
        else $error("command reply without last");

    // Every tick ends with no expiry left pending.
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcwd_pkg::ST_FLUSH && n_state == mcwd_pkg::ST_IDLE) |=> !r_pend_valid)
        else $error("expiry left pending after a tick");
`endif

endmodule
